// ----- sv/lvbd_pkg.sv -----
// Shared types, constants and helpers for the label volume boundary detector.
`default_nettype none
package lvbd_pkg;

  localparam int COORD_W          = 12;
  localparam int DIM_W            = 13;
  localparam int MAX_DIM          = 4096;
  localparam int LABEL_BITS_DEF   = 16;
  localparam int PLANE_ENTRIES_DEF = 4096;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = DIM_W;
  localparam int OUT_W            = ((3 * COORD_W + 7) / 8) * 8;
  localparam int FIFO_DEPTH       = 4;
  localparam int FIFO_PTR_W       = 2;
  localparam int FIFO_CNT_W       = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOL_WIDTH   = 2'd0,
    CFG_VOL_HEIGHT  = 2'd1,
    CFG_VOL_DEPTH   = 2'd2,
    CFG_MASK_ENABLE = 2'd3
  } lvbd_cfg_idx_t;

  // Per-item control handed from the address stage to the decision stage.
  typedef struct packed {
    logic               decide;      // voxel one plane back is checked by this item
    logic               t_first;     // t == 0
    logic               plane_last;  // last voxel of an x/t plane
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;           // already y - 1
    logic [COORD_W-1:0] t;
  } lvbd_item_t;

  // A zero dimension acts as one, an oversized one is clamped.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/lvbd_plane_mem.sv -----
// Plane delay store: one write port and two registered read ports.
`default_nettype none
module lvbd_plane_mem #(
  parameter int DATA_W = lvbd_pkg::LABEL_BITS_DEF + 1,
  parameter int DEPTH  = lvbd_pkg::PLANE_ENTRIES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [DATA_W-1:0] rdata_a,
  output logic      [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ----- sv/lvbd_ctrl.sv -----
// Configuration registers, voxel coordinates and plane store addressing.
`default_nettype none
module lvbd_ctrl #(
  parameter int PLANE_ENTRIES = lvbd_pkg::PLANE_ENTRIES_DEF,
  localparam int ADDR_W = $clog2(PLANE_ENTRIES)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [lvbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lvbd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             accept,
  output lvbd_pkg::lvbd_item_t                  item,
  output logic                                  mem_we,
  output logic      [ADDR_W-1:0]                waddr,
  output logic      [ADDR_W-1:0]                raddr_a,
  output logic      [ADDR_W-1:0]                raddr_b,
  output logic                                  mask_en
);

  localparam int DW = lvbd_pkg::DIM_W;
  localparam int CW = lvbd_pkg::COORD_W;
  localparam int PW = 2 * DW;
  localparam logic [PW-1:0] PLANE_LIM = PW'(PLANE_ENTRIES);

  logic [DW-1:0]     dim_w;
  logic [DW-1:0]     dim_h;
  logic [DW-1:0]     dim_d;
  logic [CW-1:0]     cur_x;
  logic [CW-1:0]     cur_y;
  logic [CW-1:0]     cur_t;
  logic [ADDR_W-1:0] write_ptr;

  logic [PW-1:0]     plane_size;
  logic              plane_fits;
  logic              x_last;
  logic              y_last;
  logic              t_last;
  logic              plane_last;

  assign plane_size = PW'(dim_w) * PW'(dim_d);
  assign plane_fits = (plane_size <= PLANE_LIM);
  assign t_last     = ((DW'(cur_t) + DW'(1)) == dim_d);
  assign x_last     = ((DW'(cur_x) + DW'(1)) == dim_w);
  assign y_last     = ((DW'(cur_y) + DW'(1)) == dim_h);
  assign plane_last = x_last && t_last;

  always_comb begin
    item.decide     = plane_fits && (cur_y != '0) && !x_last && !t_last;
    item.t_first    = (cur_t == '0);
    item.plane_last = plane_last;
    item.x          = cur_x;
    item.y          = cur_y - CW'(1);
    item.t          = cur_t;
  end

  // (x, t+1) and (x+1, t) of the previous plane are still unwritten here;
  // the last voxel of a plane fetches entry 0 for the next plane's first voxel.
  assign mem_we  = accept && plane_fits;
  assign waddr   = write_ptr;
  assign raddr_a = plane_last ? '0 : write_ptr + ADDR_W'(1);
  assign raddr_b = ADDR_W'(32'(write_ptr) + 32'(dim_d));

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_w     <= lvbd_pkg::DIM_RESET;
      dim_h     <= lvbd_pkg::DIM_RESET;
      dim_d     <= lvbd_pkg::DIM_RESET;
      mask_en   <= 1'b0;
      cur_x     <= '0;
      cur_y     <= '0;
      cur_t     <= '0;
      write_ptr <= '0;
    end else if (cfg_we) begin
      unique case (lvbd_pkg::lvbd_cfg_idx_t'(cfg_index))
        lvbd_pkg::CFG_VOL_WIDTH:   dim_w   <= lvbd_pkg::eff_dim(cfg_data);
        lvbd_pkg::CFG_VOL_HEIGHT:  dim_h   <= lvbd_pkg::eff_dim(cfg_data);
        lvbd_pkg::CFG_VOL_DEPTH:   dim_d   <= lvbd_pkg::eff_dim(cfg_data);
        lvbd_pkg::CFG_MASK_ENABLE: mask_en <= cfg_data[0];
        default: ;
      endcase
      cur_x     <= '0;
      cur_y     <= '0;
      cur_t     <= '0;
      write_ptr <= '0;
    end else if (accept) begin
      write_ptr <= plane_last ? '0 : write_ptr + ADDR_W'(1);
      if (t_last) begin
        cur_t <= '0;
        if (x_last) begin
          cur_x <= '0;
          cur_y <= y_last ? '0 : cur_y + CW'(1);
        end else begin
          cur_x <= cur_x + CW'(1);
        end
      end else begin
        cur_t <= cur_t + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/lvbd_decide.sv -----
// Decision stage: compares a stored voxel against its three neighbors.
`default_nettype none
module lvbd_decide #(
  parameter int LABEL_BITS = lvbd_pkg::LABEL_BITS_DEF,
  localparam int DATA_W = LABEL_BITS + 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire lvbd_pkg::lvbd_item_t           item,
  input  wire logic [LABEL_BITS-1:0]          label,
  input  wire logic [DATA_W-1:0]              rd_a,
  input  wire logic [DATA_W-1:0]              rd_b,
  input  wire logic                           mask_en,
  output logic                                s1_valid,
  output logic                                hit,
  output logic [3*lvbd_pkg::COORD_W-1:0]      pos
);

  lvbd_pkg::lvbd_item_t s1_item;
  logic [LABEL_BITS-1:0] s1_label;
  logic [DATA_W-1:0]     prev_a;
  logic [DATA_W-1:0]     head;
  logic [DATA_W-1:0]     center;
  logic                  differs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item  <= item;
      s1_label <= label;
    end
    // port A of the previous item fetched this item's own old entry;
    // head keeps the t == 0 entry of the next column
    if (s1_valid) begin
      prev_a <= rd_a;
      if (s1_item.plane_last) begin
        head <= rd_a;
      end else if (s1_item.t_first) begin
        head <= rd_b;
      end
    end
  end

  assign center  = s1_item.t_first ? head : prev_a;
  assign differs = (center[LABEL_BITS-1:0] != rd_a[LABEL_BITS-1:0]) ||
                   (center[LABEL_BITS-1:0] != rd_b[LABEL_BITS-1:0]) ||
                   (center[LABEL_BITS-1:0] != s1_label);
  assign hit     = s1_valid && s1_item.decide && differs &&
                   !(mask_en && !center[LABEL_BITS]);
  assign pos     = {s1_item.t, s1_item.y, s1_item.x};

endmodule
`default_nettype wire

// ----- sv/lvbd_out_fifo.sv -----
// Small result queue in front of the output channel.
`default_nettype none
module lvbd_out_fifo #(
  parameter int DATA_W = 3 * lvbd_pkg::COORD_W
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  input  wire logic [DATA_W-1:0]                 wdata,
  input  wire logic                              pop,
  output logic      [DATA_W-1:0]                 rdata,
  output logic                                   not_empty,
  output logic      [lvbd_pkg::FIFO_CNT_W-1:0]   count
);

  logic [DATA_W-1:0] slots [lvbd_pkg::FIFO_DEPTH];
  logic [lvbd_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [lvbd_pkg::FIFO_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + lvbd_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + lvbd_pkg::FIFO_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + lvbd_pkg::FIFO_CNT_W'(1);
        2'b01:   count <= count - lvbd_pkg::FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata     = slots[rd_ptr];
  assign not_empty = (count != '0);

endmodule
`default_nettype wire

// ----- sv/label_volume_boundary_detector.sv -----
// Top level of the label volume boundary detector.
//
// Input channel s_*: one voxel per item in memory order (y outer, x, t inner);
// tdata carries the label and its mask bit. Output channel m_*: one item per
// boundary voxel with its x, y and t coordinates. A voxel is decided when its
// y+1 neighbor arrives, so results follow in stream order one plane behind.
// The cfg_* port writes width, height, depth and mask enable; any write
// restarts the stream at the origin. Write it only while the block is idle.
//
// One item per cycle sustained while the result queue has room. A result
// shows on m_tvalid once the item that decides it has passed the registered
// reads of the plane store and the compare into the result queue.
// The plane store is read at two addresses and written at one per item;
// the stored voxel comes from earlier reads, so no interlock is needed.
// When the output stalls, the four-entry result queue fills and s_tready
// drops once no room is left for the item still in flight.
// Reset restores the register defaults (64 x 64 x 64, mask off) and the
// origin; the store needs no clearing, as every entry is written before use.
`default_nettype none
module label_volume_boundary_detector #(
  parameter int LABEL_BITS    = lvbd_pkg::LABEL_BITS_DEF,
  parameter int PLANE_ENTRIES = lvbd_pkg::PLANE_ENTRIES_DEF,
  localparam int IN_W = ((LABEL_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [IN_W-1:0]                 s_tdata,  // voxel_label, mask_flag
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [lvbd_pkg::OUT_W-1:0]      m_tdata,  // pos_x, pos_y, pos_t
  input  wire logic                            cfg_we,
  input  wire logic [lvbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lvbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(PLANE_ENTRIES);
  localparam int DATA_W = LABEL_BITS + 1;
  localparam int POS_W  = 3 * lvbd_pkg::COORD_W;
  localparam logic [lvbd_pkg::FIFO_CNT_W-1:0] READY_LIM =
    lvbd_pkg::FIFO_CNT_W'(lvbd_pkg::FIFO_DEPTH);

  logic                  accept;
  lvbd_pkg::lvbd_item_t  item;
  logic                  mem_we;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr_a;
  logic [ADDR_W-1:0]     raddr_b;
  logic                  mask_en;
  logic [DATA_W-1:0]     rd_a;
  logic [DATA_W-1:0]     rd_b;
  logic                  s1_valid;
  logic                  hit;
  logic [POS_W-1:0]      pos;
  logic [POS_W-1:0]      q_data;
  logic [lvbd_pkg::FIFO_CNT_W-1:0] q_count;
  logic                  q_not_empty;

  assign s_tready = ((q_count + lvbd_pkg::FIFO_CNT_W'(s1_valid)) < READY_LIM);
  assign accept   = s_tvalid && s_tready;

  lvbd_ctrl #(
    .PLANE_ENTRIES(PLANE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .item     (item),
    .mem_we   (mem_we),
    .waddr    (waddr),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .mask_en  (mask_en)
  );

  lvbd_plane_mem #(
    .DATA_W(DATA_W),
    .DEPTH (PLANE_ENTRIES)
  ) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (waddr),
    .wdata  (s_tdata[DATA_W-1:0]),
    .re     (accept),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  lvbd_decide #(
    .LABEL_BITS(LABEL_BITS)
  ) u_decide (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .label   (s_tdata[LABEL_BITS-1:0]),
    .rd_a    (rd_a),
    .rd_b    (rd_b),
    .mask_en (mask_en),
    .s1_valid(s1_valid),
    .hit     (hit),
    .pos     (pos)
  );

  lvbd_out_fifo #(
    .DATA_W(POS_W)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (hit),
    .wdata    (pos),
    .pop      (m_tvalid && m_tready),
    .rdata    (q_data),
    .not_empty(q_not_empty),
    .count    (q_count)
  );

  assign m_tvalid = q_not_empty;
  assign m_tdata  = lvbd_pkg::OUT_W'(q_data);

endmodule
`default_nettype wire

// ----- sv/lvbd_checker.sv -----
// Port-level checks for the boundary detector, bound to the top level.
`default_nettype none
module lvbd_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [lvbd_pkg::OUT_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result shown right after reset");

  // a new result needs a deciding item taken before it
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a deciding item");

  // the padding above the coordinates stays zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[lvbd_pkg::OUT_W-1:3*lvbd_pkg::COORD_W] == '0))
    else $error("nonzero padding in result");

  // an empty result queue never holds off the input
  a_in_room: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with an empty queue");

endmodule

bind label_volume_boundary_detector lvbd_checker u_lvbd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
`default_nettype wire
